// ===== src/bbn_pkg.sv =====
// Shared constants and types for the bounding-box normalizer.
package bbn_pkg;

  localparam int POS_W    = 16;
  localparam int COORD_W  = 16;
  localparam int MAX_VERT = 64;
  localparam int FRAC_W   = 16;
  localparam int NORM_W   = FRAC_W + 1;
  localparam int DIVD_W   = COORD_W + FRAC_W;
  localparam int IDX_W    = $clog2(MAX_VERT);
  localparam int CNT_W    = $clog2(MAX_VERT + 1);
  localparam int ITER_W   = $clog2(NORM_W + 1);
  localparam int AXES     = 3;

  typedef struct packed {
    logic load;
    logic first;
    logic start;
  } lane_ctl_t;

endpackage

// ===== src/bbn_div.sv =====
// Restoring divider, one quotient bit per cycle.
module bbn_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bbn_pkg::DIVD_W-1:0]   dividend,
  input  logic [bbn_pkg::COORD_W-1:0]  divisor,
  output logic [bbn_pkg::NORM_W-1:0]   quot,
  output logic                         busy
);
  import bbn_pkg::*;

  logic [COORD_W-1:0] rem;
  logic [NORM_W-1:0]  low;
  logic [ITER_W-1:0]  cnt;
  logic [COORD_W:0]   trial;
  logic [COORD_W:0]   diff;

  assign trial = {rem, low[NORM_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      rem  <= COORD_W'(dividend[DIVD_W-1:NORM_W]);
      low  <= dividend[NORM_W-1:0];
      quot <= '0;
      cnt  <= ITER_W'(NORM_W);
      busy <= 1'b1;
    end else if (busy) begin
      if (!diff[COORD_W]) begin
        rem  <= diff[COORD_W-1:0];
        quot <= {quot[NORM_W-2:0], 1'b1};
      end else begin
        rem  <= trial[COORD_W-1:0];
        quot <= {quot[NORM_W-2:0], 1'b0};
      end
      low <= {low[NORM_W-2:0], 1'b0};
      cnt <= cnt - 1'b1;
      if (cnt == ITER_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== src/bbn_lane.sv =====
// One axis lane: min/max tracking, span and rounded normalization.
module bbn_lane (
  input  logic                               clk,
  input  logic                               rst,
  input  bbn_pkg::lane_ctl_t                 ctl,
  input  logic signed [bbn_pkg::COORD_W-1:0] coord,
  input  logic signed [bbn_pkg::COORD_W-1:0] vtx,
  output logic [bbn_pkg::NORM_W-1:0]         result,
  output logic                               flat,
  output logic                               busy
);
  import bbn_pkg::*;

  logic signed [COORD_W-1:0] lo;
  logic signed [COORD_W-1:0] hi;
  logic [COORD_W-1:0]        span;
  logic [COORD_W-1:0]        num;
  logic [DIVD_W-1:0]         dividend;
  logic [NORM_W-1:0]         quot;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (ctl.first) begin
        lo <= coord;
        hi <= coord;
      end else begin
        if (coord < lo) begin
          lo <= coord;
        end
        if (coord > hi) begin
          hi <= coord;
        end
      end
    end
    span <= COORD_W'(hi - lo);
    flat <= (hi == lo);
  end

  // round to nearest: (num * 2^FRAC + span/2) / span
  assign num      = COORD_W'(vtx - lo);
  assign dividend = {num, FRAC_W'(0)} + DIVD_W'(span >> 1);

  bbn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.start),
    .dividend (dividend),
    .divisor  (span),
    .quot     (quot),
    .busy     (busy)
  );

  assign result = flat ? '0 : quot;

endmodule

// ===== src/bounding_box_normalize_3d.sv =====
// Top level: vertex store, run control, three axis lanes and merged result register.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------------
//   in      | in_valid / in_stall | pos_x, pos_y, pos_z, last_vertex
//   out     | out_valid/out_stall | norm_x/y/z, flat_axes, overflow, last_result
//
// Loading takes one vertex beat per cycle. After the last vertex, each stored
// vertex goes through a store read, a lane start, the 17-step divider in every
// lane and a result register load, lanes side by side.
// in_stall stays high from the last vertex until the final result is registered.
// rst is synchronous; the store needs no clearing. A stalled output holds the lanes.
module bounding_box_normalize_3d (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [bbn_pkg::POS_W-1:0]    pos_x,
  input  logic signed [bbn_pkg::POS_W-1:0]    pos_y,
  input  logic signed [bbn_pkg::POS_W-1:0]    pos_z,
  input  logic                                last_vertex,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bbn_pkg::NORM_W-1:0]          norm_x,
  output logic [bbn_pkg::NORM_W-1:0]          norm_y,
  output logic [bbn_pkg::NORM_W-1:0]          norm_z,
  output logic [bbn_pkg::AXES-1:0]            flat_axes,
  output logic                                overflow,
  output logic                                last_result
);
  import bbn_pkg::*;

  typedef enum logic [1:0] {S_LOAD, S_READ, S_START, S_DIV} state_t;

  state_t                      state;
  logic [CNT_W-1:0]            count;
  logic [IDX_W-1:0]            idx;
  logic                        ovf;
  logic [AXES*COORD_W-1:0]     mem [MAX_VERT];
  logic [AXES*COORD_W-1:0]     rd_data;
  logic                        in_acc;
  logic                        store;
  logic                        out_free;
  logic                        out_load;
  logic                        run_end;
  lane_ctl_t                   ctl;
  logic [AXES-1:0]             busy;
  logic [AXES-1:0]             flat;
  logic [NORM_W-1:0]           res [AXES];
  logic signed [COORD_W-1:0]   coord [AXES];

  assign in_stall = (state != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign store    = in_acc && (count != CNT_W'(MAX_VERT));
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == S_DIV) && (busy == '0) && out_free;
  assign run_end  = (CNT_W'(idx) + 1'b1 == count);

  assign coord[0] = pos_x[COORD_W-1:0];
  assign coord[1] = pos_y[COORD_W-1:0];
  assign coord[2] = pos_z[COORD_W-1:0];

  assign ctl.load  = store;
  assign ctl.first = (count == '0);
  assign ctl.start = (state == S_START);

  always_ff @(posedge clk) begin
    if (store) begin
      mem[count[IDX_W-1:0]] <= {coord[2], coord[1], coord[0]};
    end
    rd_data <= mem[idx];
  end

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    bbn_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .coord  (coord[a]),
      .vtx    (rd_data[a*COORD_W +: COORD_W]),
      .result (res[a]),
      .flat   (flat[a]),
      .busy   (busy[a])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      idx       <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (store) begin
            count <= count + 1'b1;
          end else if (in_acc) begin
            ovf <= 1'b1;
          end
          if (in_acc && last_vertex) begin
            idx   <= '0;
            state <= S_READ;
          end
        end
        S_READ:  state <= S_START;
        S_START: state <= S_DIV;
        S_DIV: begin
          if (out_load) begin
            norm_x      <= res[0];
            norm_y      <= res[1];
            norm_z      <= res[2];
            flat_axes   <= flat;
            overflow    <= ovf;
            last_result <= run_end;
            out_valid   <= 1'b1;
            if (run_end) begin
              count <= '0;
              ovf   <= 1'b0;
              state <= S_LOAD;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_READ;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_VERT))
    else $error("vertex count beyond store depth");

  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (CNT_W'(idx) < count))
    else $error("emission index outside stored run");

  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    (out_load && run_end) |=> (state == S_LOAD && count == '0 && !ovf))
    else $error("run state not cleared after final result");

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    (busy == '0) || (busy == '1))
    else $error("axis lanes out of step");

endmodule

// ===== dv/bounding_box_normalize_3d_tb.sv =====
// Testbench for bounding_box_normalize_3d: directed and random vertex sets checked beat by beat.
`timescale 1ns / 100ps

module bounding_box_normalize_3d_tb;
  import bbn_pkg::*;

  typedef struct packed {
    logic [NORM_W-1:0] nx, ny, nz;
    logic [AXES-1:0]   flat;
    logic              ovf;
    logic              lastr;
  } norm_beat_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x, y, z;
    logic                    last;
    logic                    typed;
    norm_beat_t              want;
  } dir_row_t;

  typedef enum int {SPAN_FULL, SPAN_TIGHT, SPAN_FLAT, SPAN_MID} span_t;

  localparam int RAND_ITEMS = 220;
  localparam int DIR_ROWS   = 17;
  localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
    '{0, 0, 0, 1, 1, '{0, 0, 0, 7, 0, 1}},
    '{-32768, -32768, -32768, 0, 1, '{0, 0, 0, 0, 0, 0}},
    '{32767, 32767, 32767, 1, 1, '{65536, 65536, 65536, 0, 0, 1}},
    '{32767, -32768, 0, 0, 1, '{65536, 0, 0, 4, 0, 0}},
    '{-32768, 32767, 0, 1, 1, '{0, 65536, 0, 4, 0, 1}},
    '{100, -5, 7, 0, 0, '0},
    '{100, 5, -7, 0, 0, '0},
    '{100, 0, 0, 1, 0, '0},
    '{0, 0, 0, 0, 0, '0},
    '{1, 1, 1, 0, 0, '0},
    '{3, 2, 3, 1, 0, '0},
    '{21845, -21846, 4660, 0, 0, '0},
    '{-21846, 21845, -4660, 0, 0, '0},
    '{0, 0, 0, 0, 0, '0},
    '{21845, 21845, 21845, 1, 0, '0},
    '{7, 7, 7, 0, 1, '{0, 0, 0, 7, 0, 0}},
    '{7, 7, 7, 1, 1, '{0, 0, 0, 7, 0, 1}}
  };

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [POS_W-1:0] pos_x = '0;
  logic signed [POS_W-1:0] pos_y = '0;
  logic signed [POS_W-1:0] pos_z = '0;
  logic                    last_vertex = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [NORM_W-1:0]       norm_x, norm_y, norm_z;
  logic [AXES-1:0]         flat_axes;
  logic                    overflow;
  logic                    last_result;

  int tx_idle_pct = 17;
  int rx_idle_pct = 49;
  int mismatch_count = 0;

  norm_beat_t expected_beats [$];

  // shadow copy of the vertex store and running bounds
  logic signed [POS_W-1:0] vstore [MAX_VERT][AXES];
  int                      slot_row [MAX_VERT];
  int                      vcount = 0;
  logic signed [POS_W-1:0] axis_lo [AXES];
  logic signed [POS_W-1:0] axis_hi [AXES];
  logic                    ovf_seen = 1'b0;

  bounding_box_normalize_3d uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [NORM_W-1:0] scale_axis(input logic signed [POS_W-1:0] v, lo, hi);
    longint num, den;
    if (hi <= lo) return '0;
    num = longint'(v) - longint'(lo);
    den = longint'(hi) - longint'(lo);
    if (num > den) num = den;
    return NORM_W'((num * 65536 + den / 2) / den);
  endfunction

  task automatic absorb_vertex(input logic signed [POS_W-1:0] x, y, z, input logic last,
                               input int row);
    logic signed [POS_W-1:0] c [AXES];
    logic [AXES-1:0]         flat;
    norm_beat_t              b;
    c = '{x, y, z};
    if (vcount < MAX_VERT) begin
      for (int a = 0; a < AXES; a++) begin
        if (vcount == 0 || c[a] < axis_lo[a]) axis_lo[a] = c[a];
        if (vcount == 0 || c[a] > axis_hi[a]) axis_hi[a] = c[a];
        vstore[vcount][a] = c[a];
      end
      slot_row[vcount] = row;
      vcount++;
    end else begin
      ovf_seen = 1'b1;
    end
    if (!last) return;
    for (int a = 0; a < AXES; a++) flat[a] = (axis_hi[a] == axis_lo[a]);
    for (int k = 0; k < vcount; k++) begin
      b.nx    = scale_axis(vstore[k][0], axis_lo[0], axis_hi[0]);
      b.ny    = scale_axis(vstore[k][1], axis_lo[1], axis_hi[1]);
      b.nz    = scale_axis(vstore[k][2], axis_lo[2], axis_hi[2]);
      b.flat  = flat;
      b.ovf   = ovf_seen;
      b.lastr = (k == vcount - 1);
      if (slot_row[k] >= 0 && DIR_TBL[slot_row[k]].typed) b = DIR_TBL[slot_row[k]].want;
      expected_beats = {expected_beats, b};
    end
    vcount   = 0;
    ovf_seen = 1'b0;
  endtask

  // entered and left at a falling edge
  task automatic send_vertex(input logic signed [POS_W-1:0] x, y, z, input logic last,
                             input int row);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    pos_x       <= x;
    pos_y       <= y;
    pos_z       <= z;
    last_vertex <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_vertex(x, y, z, last, row);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    wait (expected_beats.size() == 0);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < rx_idle_pct);

  always @(posedge clk) begin
    norm_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing pending");
        mismatch_count++;
      end else begin
        want = expected_beats.pop_front();
        check_field("norm_x", 32'(want.nx), 32'(norm_x));
        check_field("norm_y", 32'(want.ny), 32'(norm_y));
        check_field("norm_z", 32'(want.nz), 32'(norm_z));
        check_field("flat_axes", 32'(want.flat), 32'(flat_axes));
        check_field("overflow", 32'(want.ovf), 32'(overflow));
        check_field("last_result", 32'(want.lastr), 32'(last_result));
      end
    end
  end

  initial begin
    int                items, set_len, set_no;
    span_t             mode [AXES];
    logic [POS_W-1:0]  base [AXES];
    logic [POS_W-1:0]  p [AXES];
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++)
      send_vertex(DIR_TBL[r].x, DIR_TBL[r].y, DIR_TBL[r].z, DIR_TBL[r].last, r);
    items = DIR_ROWS;
    drain_results();

    // set 2 fills the store exactly, set 4 overruns it
    set_no = 0;
    while (items < RAND_ITEMS || set_no < 6) begin
      if (items < 80) begin
        tx_idle_pct = 17;
        rx_idle_pct = 49;
      end else if (items < 160) begin
        tx_idle_pct = 49;
        rx_idle_pct = 17;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (set_no == 2) set_len = MAX_VERT;
      else if (set_no == 4) set_len = MAX_VERT + $urandom_range(1, 6);
      else if ($urandom_range(99) < 70) set_len = $urandom_range(1, 8);
      else set_len = $urandom_range(9, 20);
      for (int a = 0; a < AXES; a++) begin
        mode[a] = span_t'($urandom_range(0, 3));
        base[a] = POS_W'($urandom);
      end
      for (int k = 0; k < set_len; k++) begin
        for (int a = 0; a < AXES; a++) begin
          case (mode[a])
            SPAN_FULL:  p[a] = POS_W'($urandom);
            SPAN_TIGHT: p[a] = POS_W'(base[a] + $urandom_range(0, 3));
            SPAN_FLAT:  p[a] = base[a];
            default:    p[a] = POS_W'(base[a] + $urandom_range(0, 255));
          endcase
        end
        send_vertex(p[0], p[1], p[2], k == set_len - 1, -1);
        items++;
      end
      if (set_no == 4) drain_results();
      set_no++;
    end

    drain_results();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== bounding_box_normalize_3d.f =====
src/bbn_pkg.sv
src/bbn_div.sv
src/bbn_lane.sv
src/bounding_box_normalize_3d.sv
dv/bounding_box_normalize_3d_tb.sv
